// ----- rtl/breakpoint_patch_table_core_defines.svh -----
// Assertion macros used by the checker file bpt_checker.
`ifndef BREAKPOINT_PATCH_TABLE_CORE_DEFINES_SVH
`define BREAKPOINT_PATCH_TABLE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bpt_pkg.sv -----
`timescale 1ns / 1ps
package bpt_pkg;

  localparam int MAX_ENTRIES = 16;

  localparam int OpW   = 3;
  localparam int AddrW = 31;
  localparam int SlotW = 4;
  localparam int WordW = 16;
  localparam int KindW = 3;

  localparam logic [OpW-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OpW-1:0] OP_ADD     = 3'd1;
  localparam logic [OpW-1:0] OP_DELETE  = 3'd2;
  localparam logic [OpW-1:0] OP_ENABLE  = 3'd3;
  localparam logic [OpW-1:0] OP_DISABLE = 3'd4;
  localparam logic [OpW-1:0] OP_RECORD  = 3'd5;

  localparam logic [KindW-1:0] KIND_DONE    = 3'd0;
  localparam logic [KindW-1:0] KIND_IGNORED = 3'd1;
  localparam logic [KindW-1:0] KIND_FULL    = 3'd2;
  localparam logic [KindW-1:0] KIND_TRAP    = 3'd3;
  localparam logic [KindW-1:0] KIND_RESTORE = 3'd4;

  // Write enables of the two table memories.
  typedef struct packed {
    logic addr_we;
    logic saved_we;
  } mem_we_t;

endpackage

// ----- rtl/bpt_mem.sv -----
`timescale 1ns / 1ps
module bpt_mem #(
  parameter int MaxEntries = bpt_pkg::MAX_ENTRIES,
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
  input  logic                       clk_i,
  input  logic [IdxW-1:0]            rd_idx_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  input  bpt_pkg::mem_we_t           we_i,
  input  logic [bpt_pkg::AddrW-1:0]  wr_addr_i,
  input  logic [bpt_pkg::WordW-1:0]  wr_saved_i,
  output logic [bpt_pkg::AddrW-1:0]  rd_addr_o,
  output logic [bpt_pkg::WordW-1:0]  rd_saved_o
);

  logic [bpt_pkg::AddrW-1:0] addr_mem [MaxEntries];
  logic [bpt_pkg::WordW-1:0] saved_mem [MaxEntries];

  always_ff @(posedge clk_i) begin
    if (we_i.addr_we) begin
      addr_mem[wr_idx_i] <= wr_addr_i;
    end
    if (we_i.saved_we) begin
      saved_mem[wr_idx_i] <= wr_saved_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_o  <= addr_mem[rd_idx_i];
    rd_saved_o <= saved_mem[rd_idx_i];
  end

endmodule

// ----- rtl/bpt_cmp.sv -----
`timescale 1ns / 1ps
module bpt_cmp (
  input  logic [bpt_pkg::AddrW-1:0] entry_i,
  input  logic [bpt_pkg::AddrW-1:0] key_i,
  input  logic                      fix_i,
  output logic                      match_o,
  output logic [bpt_pkg::AddrW-1:0] key_dec_o
);

  logic [bpt_pkg::AddrW-1:0] lhs;

  // In fixup mode compare against the word after the breakpoint.
  assign lhs       = fix_i ? (entry_i + 1'b1) : entry_i;
  assign match_o   = (lhs == key_i);
  assign key_dec_o = key_i - 1'b1;

endmodule

// ----- rtl/bpt_seq.sv -----
`timescale 1ns / 1ps
module bpt_seq #(
  parameter int MaxEntries = bpt_pkg::MAX_ENTRIES,
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bpt_pkg::OpW-1:0]    op_i,
  input  logic [bpt_pkg::AddrW-1:0]  address_i,
  input  logic [bpt_pkg::SlotW-1:0]  slot_i,
  input  logic [bpt_pkg::WordW-1:0]  saved_word_i,
  input  logic [bpt_pkg::AddrW-1:0]  pc_i,
  input  logic [bpt_pkg::WordW-1:0]  trap_word_i,
  input  logic [bpt_pkg::AddrW-1:0]  rd_addr_i,
  input  logic [bpt_pkg::WordW-1:0]  rd_saved_i,
  input  logic                       match_i,
  input  logic [bpt_pkg::AddrW-1:0]  key_dec_i,
  output logic [bpt_pkg::AddrW-1:0]  key_o,
  output logic                       fix_o,
  output logic [IdxW-1:0]            rd_idx_o,
  output logic [IdxW-1:0]            wr_idx_o,
  output bpt_pkg::mem_we_t           we_o,
  output logic [bpt_pkg::AddrW-1:0]  wr_addr_o,
  output logic [bpt_pkg::WordW-1:0]  wr_saved_o,
  output logic                       busy_o,
  output logic                       valid_o,
  output logic [bpt_pkg::KindW-1:0]  kind_o,
  output logic [bpt_pkg::AddrW-1:0]  mem_address_o,
  output logic [bpt_pkg::WordW-1:0]  write_word_o,
  output logic [bpt_pkg::SlotW-1:0]  slot_out_o,
  output logic [bpt_pkg::AddrW-1:0]  pc_out_o,
  output logic                       last_o
);

  localparam int CntW  = $clog2(MaxEntries + 1);
  localparam int SlotW = bpt_pkg::SlotW;
  localparam int CmpW  = (CntW > SlotW) ? CntW : SlotW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [bpt_pkg::OpW-1:0]   op_q, op_d;
  logic [bpt_pkg::AddrW-1:0] key_q, key_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [IdxW-1:0]           hit_q, hit_d;
  logic [CntW-1:0]           count_q, count_d;
  logic                      patched_q, patched_d;

  logic                      res_vld_q;
  logic                      emit;
  logic [bpt_pkg::KindW-1:0] e_kind;
  logic [bpt_pkg::AddrW-1:0] e_addr;
  logic [bpt_pkg::WordW-1:0] e_word;
  logic [bpt_pkg::SlotW-1:0] e_slot;
  logic [bpt_pkg::AddrW-1:0] e_pc;
  logic                      e_last;

  logic [CntW-1:0]           count_m1;
  logic [IdxW-1:0]           last_idx;
  logic                      at_last;
  logic [SlotW+IdxW-1:0]     idx_pad;
  logic [SlotW+IdxW-1:0]     slot_pad;
  logic [bpt_pkg::AddrW-1:0] pc_new;

  assign count_m1 = CntW'(count_q - 1'b1);
  assign last_idx = count_m1[IdxW-1:0];
  assign at_last  = (CntW'(idx_q) == count_m1);
  assign idx_pad  = {{SlotW{1'b0}}, idx_q};
  assign slot_pad = {{IdxW{1'b0}}, slot_i};
  assign pc_new   = match_i ? key_dec_i : key_q;

  assign key_o    = key_q;
  assign fix_o    = (op_q == bpt_pkg::OP_DISABLE);
  assign rd_idx_o = idx_d;
  assign busy_o   = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    count_d    = count_q;
    patched_d  = patched_q;
    we_o       = '0;
    wr_idx_o   = '0;
    wr_addr_o  = key_q;
    wr_saved_o = saved_word_i;
    emit       = 1'b0;
    e_kind     = bpt_pkg::KIND_DONE;
    e_addr     = '0;
    e_word     = '0;
    e_slot     = '0;
    e_pc       = '0;
    e_last     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = op_i;
          key_d = (op_i == bpt_pkg::OP_DISABLE) ? pc_i : address_i;
          idx_d = '0;
          unique case (op_i)
            bpt_pkg::OP_CLEAR: begin
              count_d = '0;
              emit    = 1'b1;
            end
            bpt_pkg::OP_ADD: begin
              if (count_q == '0) begin
                we_o.addr_we = 1'b1;
                wr_addr_o    = address_i;
                count_d      = CntW'(1);
                emit         = 1'b1;
              end else begin
                state_d = S_WALK;
              end
            end
            bpt_pkg::OP_DELETE: begin
              if (count_q == '0) begin
                emit   = 1'b1;
                e_kind = bpt_pkg::KIND_IGNORED;
              end else begin
                state_d = S_WALK;
              end
            end
            bpt_pkg::OP_ENABLE: begin
              patched_d = 1'b1;
              if (count_q == '0) begin
                emit = 1'b1;
              end else begin
                state_d = S_WALK;
              end
            end
            bpt_pkg::OP_DISABLE: begin
              if (!patched_q) begin
                emit   = 1'b1;
                e_kind = bpt_pkg::KIND_IGNORED;
              end else begin
                patched_d = 1'b0;
                if (count_q == '0) begin
                  emit = 1'b1;
                  e_pc = pc_i;
                end else begin
                  state_d = S_WALK;
                end
              end
            end
            bpt_pkg::OP_RECORD: begin
              emit = 1'b1;
              if (CmpW'(slot_i) < CmpW'(count_q)) begin
                we_o.saved_we = 1'b1;
                wr_idx_o      = slot_pad[IdxW-1:0];
              end else begin
                e_kind = bpt_pkg::KIND_IGNORED;
              end
            end
            default: begin
              emit   = 1'b1;
              e_kind = bpt_pkg::KIND_IGNORED;
            end
          endcase
        end
      end

      S_WALK: begin
        // Read data for idx_q arrives now; request the next entry.
        idx_d = idx_q + 1'b1;
        unique case (op_q)
          bpt_pkg::OP_ADD: begin
            if (match_i) begin
              emit    = 1'b1;
              e_kind  = bpt_pkg::KIND_IGNORED;
              state_d = S_IDLE;
            end else if (at_last) begin
              emit    = 1'b1;
              state_d = S_IDLE;
              if (count_q == CntW'(MaxEntries)) begin
                e_kind = bpt_pkg::KIND_FULL;
              end else begin
                we_o.addr_we = 1'b1;
                wr_idx_o     = count_q[IdxW-1:0];
                count_d      = CntW'(count_q + 1'b1);
              end
            end
          end
          bpt_pkg::OP_DELETE: begin
            if (match_i) begin
              if (at_last) begin
                count_d = count_m1;
                emit    = 1'b1;
                state_d = S_IDLE;
              end else begin
                // Fetch the last entry to fill the freed slot.
                hit_d   = idx_q;
                idx_d   = last_idx;
                state_d = S_MOVE;
              end
            end else if (at_last) begin
              emit    = 1'b1;
              e_kind  = bpt_pkg::KIND_IGNORED;
              state_d = S_IDLE;
            end
          end
          bpt_pkg::OP_ENABLE: begin
            emit   = 1'b1;
            e_kind = bpt_pkg::KIND_TRAP;
            e_addr = rd_addr_i;
            e_word = trap_word_i;
            e_slot = idx_pad[SlotW-1:0];
            e_last = at_last;
            if (at_last) begin
              state_d = S_IDLE;
            end
          end
          bpt_pkg::OP_DISABLE: begin
            key_d  = pc_new;
            emit   = 1'b1;
            e_kind = bpt_pkg::KIND_RESTORE;
            e_addr = rd_addr_i;
            e_word = rd_saved_i;
            e_slot = idx_pad[SlotW-1:0];
            e_pc   = pc_new;
            e_last = at_last;
            if (at_last) begin
              state_d = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_MOVE: begin
        we_o.addr_we  = 1'b1;
        we_o.saved_we = 1'b1;
        wr_idx_o      = hit_q;
        wr_addr_o     = rd_addr_i;
        wr_saved_o    = rd_saved_i;
        count_d       = count_m1;
        emit          = 1'b1;
        state_d       = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      patched_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      patched_q <= patched_d;
      res_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    idx_q <= idx_d;
    hit_q <= hit_d;
    if (emit) begin
      kind_o        <= e_kind;
      mem_address_o <= e_addr;
      write_word_o  <= e_word;
      slot_out_o    <= e_slot;
      pc_out_o      <= e_pc;
      last_o        <= e_last;
    end
  end

  assign valid_o = res_vld_q;

endmodule

// ----- rtl/breakpoint_patch_table_core.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake              | Payload
// request   | in        | start, busy            | op_i, address_i, slot_i, saved_word_i, pc_i
// result    | out       | valid_o (one cycle)    | kind_o, mem_address_o, write_word_o,
//           |           |                        | slot_out_o, pc_out_o, last_o
// config    | in        | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// Clear, record, unused ops, idle disable and empty-table requests: result the next cycle.
// Add, delete, enable, disable: walk the table through the shared read port, which returns
// one entry a cycle; add and delete stop at a hit, and a delete hit before the last entry
// passes through a move state that copies the last entry into the freed slot.
// Busy stays high for the whole walk. Results cannot be stalled by the receiver.
// Reset clears the entry count and the patched flag; table contents stay undefined.
module breakpoint_patch_table_core #(
  parameter int MaxEntries = bpt_pkg::MAX_ENTRIES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [bpt_pkg::OpW-1:0]    op_i,
  input  logic [bpt_pkg::AddrW-1:0]  address_i,
  input  logic [bpt_pkg::SlotW-1:0]  slot_i,
  input  logic [bpt_pkg::WordW-1:0]  saved_word_i,
  input  logic [bpt_pkg::AddrW-1:0]  pc_i,
  output logic                       valid_o,
  output logic [bpt_pkg::KindW-1:0]  kind_o,
  output logic [bpt_pkg::AddrW-1:0]  mem_address_o,
  output logic [bpt_pkg::WordW-1:0]  write_word_o,
  output logic [bpt_pkg::SlotW-1:0]  slot_out_o,
  output logic [bpt_pkg::AddrW-1:0]  pc_out_o,
  output logic                       last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  logic [bpt_pkg::WordW-1:0] trap_q;
  logic                      trap_sel;

  logic [IdxW-1:0]           rd_idx;
  logic [IdxW-1:0]           wr_idx;
  bpt_pkg::mem_we_t          mem_we;
  logic [bpt_pkg::AddrW-1:0] wr_addr;
  logic [bpt_pkg::WordW-1:0] wr_saved;
  logic [bpt_pkg::AddrW-1:0] rd_addr;
  logic [bpt_pkg::WordW-1:0] rd_saved;
  logic [bpt_pkg::AddrW-1:0] key;
  logic                      fix;
  logic                      match;
  logic [bpt_pkg::AddrW-1:0] key_dec;

  assign pready   = 1'b1;
  assign trap_sel = (paddr[2] == 1'b0);
  assign prdata   = trap_sel ? {16'h0000, trap_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trap_q <= '0;
    end else if (psel && penable && pwrite && pready && trap_sel) begin
      trap_q <= pwdata[bpt_pkg::WordW-1:0];
    end
  end

  bpt_mem #(
    .MaxEntries(MaxEntries)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_idx_i  (rd_idx),
    .wr_idx_i  (wr_idx),
    .we_i      (mem_we),
    .wr_addr_i (wr_addr),
    .wr_saved_i(wr_saved),
    .rd_addr_o (rd_addr),
    .rd_saved_o(rd_saved)
  );

  bpt_cmp u_cmp (
    .entry_i  (rd_addr),
    .key_i    (key),
    .fix_i    (fix),
    .match_o  (match),
    .key_dec_o(key_dec)
  );

  bpt_seq #(
    .MaxEntries(MaxEntries)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .op_i         (op_i),
    .address_i    (address_i),
    .slot_i       (slot_i),
    .saved_word_i (saved_word_i),
    .pc_i         (pc_i),
    .trap_word_i  (trap_q),
    .rd_addr_i    (rd_addr),
    .rd_saved_i   (rd_saved),
    .match_i      (match),
    .key_dec_i    (key_dec),
    .key_o        (key),
    .fix_o        (fix),
    .rd_idx_o     (rd_idx),
    .wr_idx_o     (wr_idx),
    .we_o         (mem_we),
    .wr_addr_o    (wr_addr),
    .wr_saved_o   (wr_saved),
    .busy_o       (busy),
    .valid_o      (valid_o),
    .kind_o       (kind_o),
    .mem_address_o(mem_address_o),
    .write_word_o (write_word_o),
    .slot_out_o   (slot_out_o),
    .pc_out_o     (pc_out_o),
    .last_o       (last_o)
  );

endmodule

// ----- rtl/bpt_checker.sv -----
`timescale 1ns / 1ps
`include "breakpoint_patch_table_core_defines.svh"
module bpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input logic last_o
);

  // A walk emits one result per cycle until its last one.
  `BPT_ASSERT_NEXT(a_walk_contig, clk_i, rst_ni, valid_o && !last_o, valid_o, "walk result gap")
  `BPT_ASSERT_SAME(a_walk_busy, clk_i, rst_ni, valid_o && !last_o, busy, "idle before last")
  // Every request either answers at once or starts a walk.
  `BPT_ASSERT_NEXT(a_req_answer, clk_i, rst_ni, start && !busy, busy || valid_o, "request lost")
  `BPT_ASSERT_SAME(a_end_last, clk_i, rst_ni, $fell(busy), valid_o && last_o, "walk end unmarked")

endmodule

bind breakpoint_patch_table_core bpt_checker u_bpt_checker (.*);

// ----- bench/patch_table_checker.sv -----
`timescale 1ns / 1ps
module patch_table_checker
  import bpt_pkg::*;
#(
  parameter logic [2:0] TrapWordAddr = 3'd0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [OpW-1:0]   op_i,
  input  logic [AddrW-1:0] address_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [WordW-1:0] saved_word_i,
  input  logic [AddrW-1:0] pc_i,
  input  logic             valid_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [AddrW-1:0] mem_address_i,
  input  logic [WordW-1:0] write_word_i,
  input  logic [SlotW-1:0] slot_out_i,
  input  logic [AddrW-1:0] pc_out_i,
  input  logic             last_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [2:0]       paddr_i,
  input  logic [31:0]      pwdata_i,
  input  logic             pready_i,
  output int               mismatch_count_o,
  output int               outstanding_o
);

  typedef struct {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] mem_address;
    logic [WordW-1:0] write_word;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] pc;
    logic             last;
  } patch_result_t;

  logic [AddrW-1:0] bp_addr [MAX_ENTRIES];
  logic [WordW-1:0] bp_saved[MAX_ENTRIES];
  int               bp_count;
  logic             armed;
  logic [WordW-1:0] trap_word_q;
  patch_result_t    pending_q[$];
  patch_result_t    head;
  int               fail_tally;

  function automatic void push_result(logic [KindW-1:0] kind, logic [AddrW-1:0] addr,
                                      logic [WordW-1:0] word, logic [SlotW-1:0] slot,
                                      logic [AddrW-1:0] pc, logic last);
    patch_result_t r;
    r.kind        = kind;
    r.mem_address = addr;
    r.write_word  = word;
    r.slot        = slot;
    r.pc          = pc;
    r.last        = last;
    pending_q.push_back(r);
  endfunction

  function automatic int find_entry(logic [AddrW-1:0] addr);
    for (int i = 0; i < bp_count; i++) begin
      if (bp_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Work out every result of one accepted request and advance the table.
  function automatic void predict_patch(logic [OpW-1:0] op, logic [AddrW-1:0] addr,
                                        logic [SlotW-1:0] slot, logic [WordW-1:0] word,
                                        logic [AddrW-1:0] pc);
    int idx;
    logic [AddrW-1:0] pc_now;
    logic [AddrW-1:0] next_addr;
    pc_now = pc;
    case (op)
      OP_CLEAR: begin
        bp_count = 0;
        push_result(KIND_DONE, '0, '0, '0, '0, 1'b1);
      end
      OP_ADD: begin
        if (find_entry(addr) >= 0) begin
          push_result(KIND_IGNORED, '0, '0, '0, '0, 1'b1);
        end else if (bp_count >= MAX_ENTRIES) begin
          push_result(KIND_FULL, '0, '0, '0, '0, 1'b1);
        end else begin
          bp_addr[bp_count] = addr;
          bp_count++;
          push_result(KIND_DONE, '0, '0, '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        idx = find_entry(addr);
        if (idx < 0) begin
          push_result(KIND_IGNORED, '0, '0, '0, '0, 1'b1);
        end else begin
          bp_count--;
          if (idx != bp_count) begin
            bp_addr[idx]  = bp_addr[bp_count];
            bp_saved[idx] = bp_saved[bp_count];
          end
          push_result(KIND_DONE, '0, '0, '0, '0, 1'b1);
        end
      end
      OP_ENABLE: begin
        armed = 1'b1;
        if (bp_count == 0) begin
          push_result(KIND_DONE, '0, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < bp_count; i++) begin
            push_result(KIND_TRAP, bp_addr[i], trap_word_q, SlotW'(i), '0,
                        i == bp_count - 1);
          end
        end
      end
      OP_DISABLE: begin
        if (!armed) begin
          push_result(KIND_IGNORED, '0, '0, '0, '0, 1'b1);
        end else begin
          armed = 1'b0;
          if (bp_count == 0) begin
            push_result(KIND_DONE, '0, '0, '0, pc_now, 1'b1);
          end else begin
            for (int i = 0; i < bp_count; i++) begin
              // step pc back over a trap it has already executed
              next_addr = bp_addr[i] + 1'b1;
              if (pc_now == next_addr) pc_now = pc_now - 1'b1;
              push_result(KIND_RESTORE, bp_addr[i], bp_saved[i], SlotW'(i), pc_now,
                          i == bp_count - 1);
            end
          end
        end
      end
      OP_RECORD: begin
        if (int'(slot) >= bp_count) begin
          push_result(KIND_IGNORED, '0, '0, '0, '0, 1'b1);
        end else begin
          bp_saved[slot] = word;
          push_result(KIND_DONE, '0, '0, '0, '0, 1'b1);
        end
      end
      default: push_result(KIND_IGNORED, '0, '0, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic int check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_count    = 0;
      armed       = 1'b0;
      trap_word_q = '0;
      pending_q.delete();
      fail_tally  = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (valid_i) begin
        if (pending_q.size() == 0) begin
          $error("result with nothing pending: kind %0d", kind_i);
          fail_tally++;
        end else begin
          head = pending_q.pop_front();
          fail_tally += check_field("kind", 32'(head.kind), 32'(kind_i));
          fail_tally += check_field("mem_address", 32'(head.mem_address),
                                    32'(mem_address_i));
          fail_tally += check_field("write_word", 32'(head.write_word), 32'(write_word_i));
          fail_tally += check_field("slot_out", 32'(head.slot), 32'(slot_out_i));
          fail_tally += check_field("pc_out", 32'(head.pc), 32'(pc_out_i));
          fail_tally += check_field("last", 32'(head.last), 32'(last_i));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == TrapWordAddr) begin
        trap_word_q = pwdata_i[WordW-1:0];
      end
      if (start_i && !busy_i) begin
        predict_patch(op_i, address_i, slot_i, saved_word_i, pc_i);
      end
      mismatch_count_o <= fail_tally;
      outstanding_o    <= pending_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import bpt_pkg::*;

  typedef logic [OpW-1:0]   op_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [SlotW-1:0] slot_t;
  typedef logic [WordW-1:0] word_t;

  localparam logic [2:0] TrapWordAddr = 3'd0;
  localparam op_t        OpSpareLo    = 3'd6;
  localparam op_t        OpSpareHi    = 3'd7;
  localparam int         CycleLimit   = 300000;
  localparam int         DrainLimit   = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  op_t         op_i = '0;
  addr_t       address_i = '0;
  slot_t       slot_i = '0;
  word_t       saved_word_i = '0;
  addr_t       pc_i = '0;
  logic        valid_o;
  logic [KindW-1:0] kind_o;
  addr_t       mem_address_o;
  word_t       write_word_o;
  slot_t       slot_out_o;
  addr_t       pc_out_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  int sent = 0;
  int idle_pct = 0;

  // Light view of the table, used only to shape legal and useful requests.
  addr_t tab_addr[MAX_ENTRIES];
  bit    saved_ok[MAX_ENTRIES];
  int    tab_n = 0;
  bit    armed = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  breakpoint_patch_table_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .address_i    (address_i),
    .slot_i       (slot_i),
    .saved_word_i (saved_word_i),
    .pc_i         (pc_i),
    .valid_o      (valid_o),
    .kind_o       (kind_o),
    .mem_address_o(mem_address_o),
    .write_word_o (write_word_o),
    .slot_out_o   (slot_out_o),
    .pc_out_o     (pc_out_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  patch_table_checker #(
    .TrapWordAddr(TrapWordAddr)
  ) table_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .op_i            (op_i),
    .address_i       (address_i),
    .slot_i          (slot_i),
    .saved_word_i    (saved_word_i),
    .pc_i            (pc_i),
    .valid_i         (valid_o),
    .kind_i          (kind_o),
    .mem_address_i   (mem_address_o),
    .write_word_i    (write_word_o),
    .slot_out_i      (slot_out_o),
    .pc_out_i        (pc_out_o),
    .last_i          (last_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  function automatic addr_t rnd_addr();
    return addr_t'($urandom());
  endfunction

  function automatic word_t rnd_word();
    return word_t'($urandom());
  endfunction

  // Mix of fresh addresses, duplicates and neighbors of table entries.
  function automatic addr_t pick_addr();
    int k;
    addr_t base;
    k = $urandom_range(3);
    if (tab_n == 0 || k < 2) return rnd_addr();
    base = tab_addr[$urandom_range(tab_n - 1)];
    if (k == 2) return base;
    return $urandom_range(1) ? base + 1'b1 : base - 1'b1;
  endfunction

  task automatic send_request(input op_t o, input addr_t a, input slot_t s,
                              input word_t w, input addr_t p);
    int idx;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    op_i         <= o;
    address_i    <= a;
    slot_i       <= s;
    saved_word_i <= w;
    pc_i         <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (o <= OP_RECORD) sent++;
    idx = -1;
    for (int i = 0; i < tab_n; i++) begin
      if (idx < 0 && tab_addr[i] == a) idx = i;
    end
    case (o)
      OP_CLEAR: tab_n = 0;
      OP_ADD: begin
        if (idx < 0 && tab_n < MAX_ENTRIES) begin
          tab_addr[tab_n] = a;
          tab_n++;
        end
      end
      OP_DELETE: begin
        if (idx >= 0) begin
          tab_n--;
          tab_addr[idx] = tab_addr[tab_n];
          saved_ok[idx] = saved_ok[tab_n];
        end
      end
      OP_ENABLE:  armed = 1'b1;
      OP_DISABLE: armed = 1'b0;
      OP_RECORD: begin
        if (int'(s) < tab_n) saved_ok[s] = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Never restore a slot whose original word was not handed back yet.
  task automatic issue(input op_t o, input addr_t a, input slot_t s,
                       input word_t w, input addr_t p);
    if (o == OP_DISABLE && armed) begin
      for (int i = 0; i < tab_n; i++) begin
        if (!saved_ok[i]) send_request(OP_RECORD, rnd_addr(), slot_t'(i), rnd_word(), rnd_addr());
      end
    end
    send_request(o, a, s, w, p);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while ((outstanding != 0 || busy) && n < DrainLimit) begin
      n++;
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_trap_word(input logic [31:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TrapWordAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    issue(OP_DISABLE, rnd_addr(), '0, rnd_word(), rnd_addr());
    issue(OP_ENABLE, rnd_addr(), '0, rnd_word(), rnd_addr());
    issue(OP_DISABLE, rnd_addr(), '0, rnd_word(), 31'h7FFF_FFFF);
    issue(OP_DELETE, 31'h0000_1234, '0, rnd_word(), rnd_addr());
    issue(OP_RECORD, rnd_addr(), 4'hF, 16'hFFFF, rnd_addr());
    issue(OpSpareLo, rnd_addr(), slot_t'(rnd_word()), rnd_word(), rnd_addr());
    issue(OpSpareHi, rnd_addr(), slot_t'(rnd_word()), rnd_word(), rnd_addr());
    issue(OP_ADD, 31'h7FFF_FFFF, '0, '0, '0);
    issue(OP_ADD, 31'h0000_0000, '0, '0, '0);
    issue(OP_ADD, 31'h7FFF_FFFE, '0, '0, '0);
    issue(OP_ADD, 31'h0000_0000, '0, '0, '0);
    issue(OP_RECORD, '0, 4'd3, rnd_word(), '0);
    issue(OP_ENABLE, '0, '0, '0, '0);
    issue(OP_ENABLE, '0, '0, '0, '0);
    issue(OP_RECORD, '0, 4'd0, 16'hFFFF, '0);
    issue(OP_RECORD, '0, 4'd1, 16'h0000, '0);
    issue(OP_RECORD, '0, 4'd2, 16'h5A5A, '0);
    // pc 0 wraps onto the top entry, then chains onto its lower neighbor
    issue(OP_DISABLE, '0, '0, '0, 31'h0000_0000);
    issue(OP_DELETE, 31'h0000_0000, '0, '0, '0);
    issue(OP_DELETE, 31'h7FFF_FFFE, '0, '0, '0);
    issue(OP_CLEAR, rnd_addr(), slot_t'(rnd_word()), rnd_word(), rnd_addr());
  endtask

  task automatic run_random(input int target);
    int pick;
    addr_t pc;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        if ($urandom_range(2) == 0) issue(OP_CLEAR, rnd_addr(), '0, rnd_word(), rnd_addr());
        repeat ($urandom_range(1, 5)) issue(OP_ADD, pick_addr(), '0, rnd_word(), rnd_addr());
        issue(OP_ENABLE, rnd_addr(), '0, rnd_word(), rnd_addr());
        for (int i = 0; i < tab_n; i++) begin
          issue(OP_RECORD, rnd_addr(), slot_t'(i), rnd_word(), rnd_addr());
        end
        if ($urandom_range(1)) begin
          issue($urandom_range(1) ? OP_DELETE : OP_ADD, pick_addr(), '0, rnd_word(),
                rnd_addr());
        end
        pc = rnd_addr();
        if (tab_n > 0 && $urandom_range(1)) pc = tab_addr[$urandom_range(tab_n - 1)] + 1'b1;
        issue(OP_DISABLE, rnd_addr(), '0, rnd_word(), pc);
      end else if (pick < 62) begin
        // fill up, then overflow
        while (tab_n < MAX_ENTRIES) issue(OP_ADD, rnd_addr(), '0, rnd_word(), rnd_addr());
        repeat ($urandom_range(1, 2)) issue(OP_ADD, pick_addr(), '0, rnd_word(), rnd_addr());
      end else if (pick < 77) begin
        repeat ($urandom_range(1, 3)) issue(OP_DELETE, pick_addr(), slot_t'(rnd_word()),
                                            rnd_word(), rnd_addr());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          issue(op_t'($urandom_range(7)), pick_addr(), slot_t'($urandom()), rnd_word(),
                $urandom_range(1) ? rnd_addr() : pick_addr() + 1'b1);
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_trap_word(32'h0000_FFFF);
    idle_pct = 0;
    run_directed();
    run_random(55);

    write_trap_word(32'h0000_0000);
    idle_pct = 80;
    run_random(110);

    write_trap_word($urandom());
    idle_pct = 18;
    run_random(160);

    write_trap_word($urandom());
    idle_pct = 0;
    run_random(210);

    wait_drained();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
